// File: design/nvt_pkg.sv
// nvt_pkg: shared constants, codes and controller/datapath structs for the
// named value table. No dependencies; used by every module of the block.

package nvt_pkg;

    localparam int ENTRIES   = 16;
    localparam int KEY_BYTES = 8;

    localparam int KEY_W     = 64;
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 4;
    localparam int COUNT_W   = 5;

    // entry index and occupancy widths follow from the table depth
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 2'd0,
        CMD_GET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_ZERO  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_EXEC = 2'd1,
        FSM_SCAN = 2'd2,
        FSM_ZERO = 2'd3
    } t_state;

    typedef enum logic [2:0] {
        FIN_NONE  = 3'd0,
        FIN_EMPTY = 3'd1,
        FIN_CLEAR = 3'd2,
        FIN_ZERO  = 3'd3,
        FIN_HIT   = 3'd4,
        FIN_MISS  = 3'd5
    } t_finish;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    scan_step;
        logic    zero_step;
        t_finish finish;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic key_empty;
        logic hit;
        logic miss;
        logic sweep_done;
        logic out_free;
    } t_stat;

endpackage

// File: design/nvt_ctrl.sv
// nvt_ctrl: sequencing state machine for the named value table.
// Depends on nvt_pkg; drives nvt_dp through t_ctrl and reads back t_stat.

module nvt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  nvt_pkg::t_stat i_stat,
    output logic           o_ready,
    output nvt_pkg::t_ctrl o_ctrl
);

    nvt_pkg::t_state r_state;
    nvt_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nvt_pkg::FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state          = r_state;
        o_ready          = 1'b0;
        o_ctrl.load      = 1'b0;
        o_ctrl.scan_step = 1'b0;
        o_ctrl.zero_step = 1'b0;
        o_ctrl.finish    = nvt_pkg::FIN_NONE;
        unique case (r_state)
            nvt_pkg::FSM_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_ctrl.load = 1'b1;
                    n_state     = nvt_pkg::FSM_EXEC;
                end
            end
            nvt_pkg::FSM_EXEC: begin
                unique case (i_stat.op)
                    nvt_pkg::CMD_SET, nvt_pkg::CMD_GET: begin
                        if (i_stat.key_empty) begin
                            if (i_stat.out_free) begin
                                o_ctrl.finish = nvt_pkg::FIN_EMPTY;
                                n_state       = nvt_pkg::FSM_IDLE;
                            end
                        end else begin
                            n_state = nvt_pkg::FSM_SCAN;
                        end
                    end
                    nvt_pkg::CMD_CLEAR: begin
                        if (i_stat.out_free) begin
                            o_ctrl.finish = nvt_pkg::FIN_CLEAR;
                            n_state       = nvt_pkg::FSM_IDLE;
                        end
                    end
                    nvt_pkg::CMD_ZERO: begin
                        n_state = nvt_pkg::FSM_ZERO;
                    end
                    default: begin
                        n_state = nvt_pkg::FSM_IDLE;
                    end
                endcase
            end
            nvt_pkg::FSM_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if ((i_stat.hit || i_stat.miss) && i_stat.out_free) begin
                    o_ctrl.finish = i_stat.hit ? nvt_pkg::FIN_HIT : nvt_pkg::FIN_MISS;
                    n_state       = nvt_pkg::FSM_IDLE;
                end
            end
            nvt_pkg::FSM_ZERO: begin
                o_ctrl.zero_step = 1'b1;
                if (i_stat.sweep_done && i_stat.out_free) begin
                    o_ctrl.finish = nvt_pkg::FIN_ZERO;
                    n_state       = nvt_pkg::FSM_IDLE;
                end
            end
            default: begin
                n_state = nvt_pkg::FSM_IDLE;
            end
        endcase
    end

endmodule

// File: design/nvt_dp.sv
// nvt_dp: key and value stores, scan pointer, occupancy count and result
// register of the named value table. Depends on nvt_pkg; steered by nvt_ctrl.

module nvt_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  nvt_pkg::t_ctrl                  i_ctrl,
    input  logic [nvt_pkg::CMD_W-1:0]       i_command,
    input  logic [nvt_pkg::KEY_W-1:0]       i_key,
    input  logic [nvt_pkg::VALUE_W-1:0]     i_payload,
    input  logic                            i_stall,
    output nvt_pkg::t_stat                  o_stat,
    output logic                            o_valid,
    output logic [nvt_pkg::STATUS_W-1:0]    o_status,
    output logic [nvt_pkg::SLOT_W-1:0]      o_slot,
    output logic [nvt_pkg::VALUE_W-1:0]     o_read_value,
    output logic [nvt_pkg::COUNT_W-1:0]     o_entry_count
);

    logic [nvt_pkg::KEY_W-1:0]   key_mem [nvt_pkg::ENTRIES];
    logic [nvt_pkg::VALUE_W-1:0] value_mem [nvt_pkg::ENTRIES];

    nvt_pkg::t_op                r_op;
    logic [nvt_pkg::KEY_W-1:0]   r_key;
    logic [nvt_pkg::VALUE_W-1:0] r_payload;

    logic [nvt_pkg::CNT_W-1:0]   r_occ;
    logic [nvt_pkg::CNT_W-1:0]   n_occ;
    logic [nvt_pkg::CNT_W-1:0]   r_scan_idx;
    logic [nvt_pkg::IDX_W-1:0]   r_cmp_idx;
    logic                        r_cmp_vld;
    logic [nvt_pkg::KEY_W-1:0]   r_key_q;
    logic [nvt_pkg::VALUE_W-1:0] r_val_q;

    logic                        r_o_valid;
    nvt_pkg::t_status            r_status;
    nvt_pkg::t_status            n_status;
    logic [nvt_pkg::SLOT_W-1:0]  r_slot;
    logic [nvt_pkg::SLOT_W-1:0]  n_slot;
    logic [nvt_pkg::VALUE_W-1:0] r_rd;
    logic [nvt_pkg::VALUE_W-1:0] n_rd;
    logic [nvt_pkg::COUNT_W-1:0] r_count;

    logic [nvt_pkg::KEY_W-1:0]   norm_key;
    logic                        alive;
    logic                        hit;
    logic                        miss;
    logic                        scan_end;
    logic                        full;
    logic                        val_we;
    logic                        key_we;
    logic [nvt_pkg::IDX_W-1:0]   waddr;
    logic [nvt_pkg::VALUE_W-1:0] wdata;

    // name ends at its first zero byte, bytes past KEY_BYTES never count
    always_comb begin
        norm_key = '0;
        alive    = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b < nvt_pkg::KEY_BYTES) begin
                alive = alive && (i_key[8*b +: 8] != 8'd0);
                if (alive) begin
                    norm_key[8*b +: 8] = i_key[8*b +: 8];
                end
            end
        end
    end

    assign scan_end = (r_scan_idx >= r_occ);
    assign hit      = r_cmp_vld && (r_key_q == r_key);
    assign miss     = !r_cmp_vld && scan_end;
    assign full     = (r_occ == nvt_pkg::CNT_W'(nvt_pkg::ENTRIES));

    assign o_stat.op         = r_op;
    assign o_stat.key_empty  = (r_key[7:0] == 8'd0);
    assign o_stat.hit        = hit;
    assign o_stat.miss       = miss;
    assign o_stat.sweep_done = scan_end;
    assign o_stat.out_free   = !r_o_valid || !i_stall;

    // result fields and store writes for the finishing command and the zero sweep
    always_comb begin
        n_status = nvt_pkg::ST_OK;
        n_slot   = '0;
        n_rd     = '0;
        n_occ    = r_occ;
        val_we   = 1'b0;
        key_we   = 1'b0;
        waddr    = r_scan_idx[nvt_pkg::IDX_W-1:0];
        wdata    = '0;
        unique case (i_ctrl.finish)
            nvt_pkg::FIN_NONE: begin
                // zero sweep writes one occupied entry a cycle
                if (i_ctrl.zero_step && !scan_end) begin
                    val_we = 1'b1;
                end
            end
            nvt_pkg::FIN_EMPTY: begin
                n_status = nvt_pkg::ST_EMPTY;
            end
            nvt_pkg::FIN_CLEAR: begin
                n_occ = '0;
            end
            nvt_pkg::FIN_ZERO: begin
                n_status = nvt_pkg::ST_OK;
            end
            nvt_pkg::FIN_HIT: begin
                n_slot = nvt_pkg::SLOT_W'(r_cmp_idx);
                if (r_op == nvt_pkg::CMD_GET) begin
                    n_rd = r_val_q;
                end else begin
                    val_we = 1'b1;
                    waddr  = r_cmp_idx;
                    wdata  = r_payload;
                end
            end
            nvt_pkg::FIN_MISS: begin
                if (r_op == nvt_pkg::CMD_GET) begin
                    n_status = nvt_pkg::ST_MISSING;
                end else if (full) begin
                    n_status = nvt_pkg::ST_FULL;
                end else begin
                    val_we = 1'b1;
                    key_we = 1'b1;
                    waddr  = r_occ[nvt_pkg::IDX_W-1:0];
                    wdata  = r_payload;
                    n_slot = nvt_pkg::SLOT_W'(r_occ);
                    n_occ  = nvt_pkg::CNT_W'(r_occ + 1'b1);
                end
            end
            default: begin
                n_status = nvt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            value_mem[waddr] <= wdata;
        end
        if (key_we) begin
            key_mem[waddr] <= r_key;
        end
        // a matched entry is held while its result waits for the output
        if (!hit) begin
            r_key_q <= key_mem[r_scan_idx[nvt_pkg::IDX_W-1:0]];
            r_val_q <= value_mem[r_scan_idx[nvt_pkg::IDX_W-1:0]];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ      <= '0;
            r_scan_idx <= '0;
            r_cmp_vld  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_ctrl.load) begin
                r_scan_idx <= '0;
                r_cmp_vld  <= 1'b0;
            end else if (i_ctrl.scan_step && !hit && !miss) begin
                // read issued now is compared next cycle
                r_cmp_vld <= !scan_end;
                if (!scan_end) begin
                    r_scan_idx <= nvt_pkg::CNT_W'(r_scan_idx + 1'b1);
                end
            end else if (i_ctrl.zero_step && !scan_end) begin
                r_scan_idx <= nvt_pkg::CNT_W'(r_scan_idx + 1'b1);
            end
            if (i_ctrl.finish != nvt_pkg::FIN_NONE) begin
                r_occ     <= n_occ;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op      <= nvt_pkg::t_op'(i_command);
            r_key     <= norm_key;
            r_payload <= i_payload;
        end
        if (i_ctrl.scan_step && !hit && !miss && !scan_end) begin
            r_cmp_idx <= r_scan_idx[nvt_pkg::IDX_W-1:0];
        end
        if (i_ctrl.finish != nvt_pkg::FIN_NONE) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_rd     <= n_rd;
            r_count  <= nvt_pkg::COUNT_W'(n_occ);
        end
    end

    assign o_valid       = r_o_valid;
    assign o_status      = r_status;
    assign o_slot        = r_slot;
    assign o_read_value  = r_rd;
    assign o_entry_count = r_count;

endmodule

// File: design/named_value_table_core.sv
// named_value_table_core: fixed-capacity table of named 32-bit values.
// set and get scan the key store one entry a cycle through its read port, each
// read registered and then compared with the key; clear and empty key finish
// from the exec state, and zero-values sweeps the occupied entries.
// one item at a time; the next transfer can be taken in the same cycle that the result appears.
// reset clears the control state and the entry count; the stores are not swept
module named_value_table_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [nvt_pkg::CMD_W-1:0]       i_command,
    input  logic [nvt_pkg::KEY_W-1:0]       i_key,
    input  logic [nvt_pkg::VALUE_W-1:0]     i_payload,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [nvt_pkg::STATUS_W-1:0]    o_status,
    output logic [nvt_pkg::SLOT_W-1:0]      o_slot,
    output logic [nvt_pkg::VALUE_W-1:0]     o_read_value,
    output logic [nvt_pkg::COUNT_W-1:0]     o_entry_count
);

    nvt_pkg::t_ctrl ctrl;
    nvt_pkg::t_stat stat;
    logic           ready;

    assign o_stall = !ready;

    nvt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_ready (ready),
        .o_ctrl  (ctrl)
    );

    nvt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_payload     (i_payload),
        .i_stall       (i_stall),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_slot        (o_slot),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

endmodule

// File: tb/named_value_table_checker.sv
`timescale 1ns / 100ps
// named_value_table_checker: watches the command and reply channels of the table
// core, keeps its own copy of the table and compares every reply field by field.
// Depends on nvt_pkg for widths, command codes and status codes.

module named_value_table_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_valid,
    input  logic                            i_cmd_stall,
    input  logic [nvt_pkg::CMD_W-1:0]       i_command,
    input  logic [nvt_pkg::KEY_W-1:0]       i_key,
    input  logic [nvt_pkg::VALUE_W-1:0]     i_payload,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_stall,
    input  logic [nvt_pkg::STATUS_W-1:0]    i_status,
    input  logic [nvt_pkg::SLOT_W-1:0]      i_slot,
    input  logic [nvt_pkg::VALUE_W-1:0]     i_read_value,
    input  logic [nvt_pkg::COUNT_W-1:0]     i_entry_count,
    output int                              o_fail_count,
    output int                              o_pending
);
    import nvt_pkg::*;

    typedef struct packed {
        t_status              status;
        logic [SLOT_W-1:0]    slot;
        logic [VALUE_W-1:0]   value;
        logic [COUNT_W-1:0]   count;
    } t_reply;

    logic [KEY_W-1:0]   key_tbl [ENTRIES];
    logic [VALUE_W-1:0] val_tbl [ENTRIES];
    int                 used;
    t_reply             expected_replies [$];

    // the name stops at its first zero byte, anything above it is ignored
    function automatic logic [KEY_W-1:0] trim_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] k;
        logic             ended;
        k     = '0;
        ended = 1'b0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (raw[8*i +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                k[8*i +: 8] = raw[8*i +: 8];
        end
        return k;
    endfunction

    function automatic int find_slot(input logic [KEY_W-1:0] k);
        int hit;
        hit = -1;
        for (int i = 0; i < used; i++) begin
            if (hit < 0 && key_tbl[i] == k)
                hit = i;
        end
        return hit;
    endfunction

    function automatic t_reply apply_command(input t_op op, input logic [KEY_W-1:0] raw,
                                             input logic [VALUE_W-1:0] payload);
        t_reply           r;
        logic [KEY_W-1:0] k;
        int               idx;
        r.status = ST_OK;
        r.slot   = '0;
        r.value  = '0;
        k        = trim_key(raw);
        case (op)
            CMD_SET: begin
                if (k == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    idx = find_slot(k);
                    if (idx >= 0) begin
                        val_tbl[idx] = payload;
                        r.slot       = idx[SLOT_W-1:0];
                    end else if (used >= ENTRIES) begin
                        r.status = ST_FULL;
                    end else begin
                        key_tbl[used] = k;
                        val_tbl[used] = payload;
                        r.slot        = used[SLOT_W-1:0];
                        used++;
                    end
                end
            end
            CMD_GET: begin
                if (k == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    idx = find_slot(k);
                    if (idx >= 0) begin
                        r.value = val_tbl[idx];
                        r.slot  = idx[SLOT_W-1:0];
                    end else begin
                        r.status = ST_MISSING;
                    end
                end
            end
            CMD_CLEAR: begin
                used = 0;
            end
            default: begin
                for (int i = 0; i < used; i++)
                    val_tbl[i] = '0;
            end
        endcase
        r.count = used[COUNT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_reply want;
        if (!i_rst_n) begin
            used = 0;
            expected_replies.delete();
        end else begin
            if (i_cmd_valid && !i_cmd_stall)
                expected_replies.push_back(apply_command(t_op'(i_command), i_key, i_payload));
            if (i_rsp_valid && !i_rsp_stall) begin
                if (expected_replies.size() == 0) begin
                    $error("reply transfer with no command outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_replies.pop_front();
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        o_fail_count++;
                    end
                    if (i_slot !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, i_slot);
                        o_fail_count++;
                    end
                    if (i_read_value !== want.value) begin
                        $error("read_value: expected %h, got %h", want.value, i_read_value);
                        o_fail_count++;
                    end
                    if (i_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count,
                               i_entry_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending <= expected_replies.size();
    end

endmodule

// File: tb/named_value_table_core_test.sv
`timescale 1ns / 100ps
// named_value_table_core_test: drives commands into the table core with random
// idling and back-pressure and gives the verdict. Depends on nvt_pkg, the core
// and named_value_table_checker, which does the prediction and comparison.

module named_value_table_core_test;
    import nvt_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int ITEMS_PER_PHASE = 567;
    localparam int POOL_SIZE       = 32;
    localparam int HOLD_AT         = 150;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 40;
    localparam int CYCLE_LIMIT     = 500000;

    localparam logic [KEY_W-1:0] KEY_MAX      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [KEY_W-1:0] KEY_ONE      = 64'h0000_0000_0000_0001;
    localparam logic [KEY_W-1:0] KEY_ONE_TAIL = 64'hDEAD_BEEF_0000_0001;
    localparam logic [KEY_W-1:0] KEY_BLANK    = 64'hFFFF_FFFF_FFFF_FF00;
    localparam logic [KEY_W-1:0] KEY_SPARE    = 64'h0000_0000_0000_7A7A;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic [CMD_W-1:0]       i_command  = '0;
    logic [KEY_W-1:0]       i_key      = '0;
    logic [VALUE_W-1:0]     i_payload  = '0;
    logic                   i_stall    = 1'b0;
    logic                   o_stall;
    logic                   o_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [SLOT_W-1:0]      o_slot;
    logic [VALUE_W-1:0]     o_read_value;
    logic [COUNT_W-1:0]     o_entry_count;

    int fail_count;
    int pending;
    int send_idle;
    int recv_idle;
    int replies_seen;
    int hold_left;
    bit hold_done;
    int cycle_count;

    logic [KEY_W-1:0] name_pool [POOL_SIZE];
    int               name_len  [POOL_SIZE];

    always #CLK_HALF i_clk = ~i_clk;

    named_value_table_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_payload      (i_payload),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_read_value   (o_read_value),
        .o_entry_count  (o_entry_count)
    );

    named_value_table_checker u_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (i_valid),
        .i_cmd_stall    (o_stall),
        .i_command      (i_command),
        .i_key          (i_key),
        .i_payload      (i_payload),
        .i_rsp_valid    (o_valid),
        .i_rsp_stall    (i_stall),
        .i_status       (o_status),
        .i_slot         (o_slot),
        .i_read_value   (o_read_value),
        .i_entry_count  (o_entry_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // reply side: random stalls plus one long hold-off so the core backs up
    initial begin
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall)
                replies_seen++;
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && replies_seen >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send(input t_op op, input logic [KEY_W-1:0] key,
                        input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= op;
        i_key     <= key;
        i_payload <= value;
        do @(posedge i_clk); while (o_stall);
    endtask

    // stop offering and wait for every outstanding reply
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [KEY_W-1:0] random_name(input int len);
        logic [KEY_W-1:0] k;
        logic [7:0]       b;
        k = '0;
        for (int i = 0; i < len; i++) begin
            b           = 8'($urandom_range(255, 1));
            k[8*i +: 8] = b;
        end
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        int               r;
        int               pick;
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] junk;
        r    = $urandom_range(99);
        junk = {$urandom, $urandom};
        if (r < 6)
            return junk;
        if (r < 10)
            return {junk[KEY_W-1:8], 8'h00};
        pick = $urandom_range(POOL_SIZE - 1);
        k    = name_pool[pick];
        // garbage above the terminator must still match the short name
        if (name_len[pick] < 7 && $urandom_range(3) == 0)
            k = k | (junk << (8 * (name_len[pick] + 1)));
        return k;
    endfunction

    function automatic t_op random_op();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return CMD_SET;
        if (r < 90)
            return CMD_GET;
        if (r < 92)
            return CMD_CLEAR;
        return CMD_ZERO;
    endfunction

    function automatic logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    initial begin
        logic [7:0] tag;
        send_idle = 30;
        recv_idle = 65;
        for (int i = 0; i < POOL_SIZE; i++) begin
            name_len[i]  = (i < 4) ? 8 : $urandom_range(8, 1);
            name_pool[i] = random_name(name_len[i]);
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(CMD_GET, KEY_ONE, '1);
        send(CMD_CLEAR, KEY_MAX, '1);
        send(CMD_SET, KEY_BLANK, 32'h1234_5678);
        send(CMD_GET, KEY_BLANK, '0);
        send(CMD_SET, KEY_MAX, '1);
        send(CMD_SET, KEY_ONE, '0);
        send(CMD_SET, KEY_ONE_TAIL, 32'h8000_0001);
        send(CMD_GET, KEY_MAX, '0);
        send(CMD_GET, KEY_ONE, '0);
        send(CMD_ZERO, KEY_BLANK, '1);
        send(CMD_GET, KEY_MAX, '0);
        for (int i = 0; i < ENTRIES - 2; i++) begin
            tag = 8'h30 + 8'(i);
            send(CMD_SET, {48'h0, tag, 8'h41}, $urandom);
        end
        send(CMD_SET, KEY_SPARE, 32'hCAFE_F00D);
        send(CMD_SET, KEY_MAX, 32'h5555_AAAA);
        send(CMD_GET, KEY_SPARE, '0);
        send(CMD_CLEAR, '0, '0);
        send(CMD_GET, KEY_ONE, '0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle = 30;
                    recv_idle = 65;
                end
                1: begin
                    send_idle = 65;
                    recv_idle = 30;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
                send(random_op(), random_key(), random_value());
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
design/nvt_pkg.sv
design/nvt_ctrl.sv
design/nvt_dp.sv
design/named_value_table_core.sv
tb/named_value_table_checker.sv
tb/named_value_table_core_test.sv
